// ----- hw/rtl/load_event_detector_core_macros.svh -----
// Assertion macros shared by the load event detector RTL.
// Each body expands to a labeled concurrent assertion with an active-low
// reset disable; synthesis builds see empty bodies.
`ifndef LOAD_EVENT_DETECTOR_CORE_MACROS_SVH
`define LOAD_EVENT_DETECTOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define LED_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");
`define LED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define LED_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/led_pkg.sv -----
`default_nettype none

package led_pkg;

  // Configuration register widths and indexes
  localparam int unsigned THR_BITS      = 10;
  localparam int unsigned DELAY_BITS    = 32;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned CFG_IDX_BITS  = 1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DELAY     = 1'b1;

  localparam logic [THR_BITS-1:0]   THR_RESET   = 10'd300;
  localparam logic [DELAY_BITS-1:0] DELAY_RESET = 32'd5000;

  // Bits of growth from scaling the power change by one thousand
  localparam int unsigned SCALE_BITS = 10;

  // Event kinds
  localparam int unsigned KIND_BITS = 3;
  localparam logic [KIND_BITS-1:0] KIND_ON_BASIC        = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_OFF             = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_ON_AFTER_FALL   = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_ON_AFTER_SETTLE = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_ON_DELAYED      = 3'd4;

  // Phase codes of the event machine
  localparam int unsigned PHASE_BITS = 3;
  localparam logic [PHASE_BITS-1:0] PH_IDLE     = 3'd0;
  localparam logic [PHASE_BITS-1:0] PH_RISE     = 3'd1;
  localparam logic [PHASE_BITS-1:0] PH_ON_WAIT  = 3'd2;
  localparam logic [PHASE_BITS-1:0] PH_FALL     = 3'd3;
  localparam logic [PHASE_BITS-1:0] PH_OFF_WAIT = 3'd4;
  localparam logic [PHASE_BITS-1:0] PH_DROP     = 3'd5;
  localparam logic [PHASE_BITS-1:0] PH_SETTLE   = 3'd6;
  localparam logic [PHASE_BITS-1:0] PH_DELAYED  = 3'd7;

  // Classification of one power change
  typedef struct packed {
    logic rise;
    logic fall;
    logic steady;
  } led_class_t;

endpackage

`default_nettype wire

// ----- hw/rtl/led_in_if.sv -----
`default_nettype none

interface led_in_if #(
  parameter int unsigned POWER_BITS = 24,
  parameter int unsigned TIME_BITS  = 32
) ();
  logic                  valid;
  logic                  ready;
  logic [POWER_BITS-1:0] power;
  logic [TIME_BITS-1:0]  sample_time;

  modport source (output valid, output power, output sample_time, input ready);
  modport sink   (input valid, input power, input sample_time, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/led_out_if.sv -----
`default_nettype none

interface led_out_if #(
  parameter int unsigned TIME_BITS = 32
) ();
  import led_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [KIND_BITS-1:0] event_kind;
  logic [TIME_BITS-1:0] event_time;

  modport source (output valid, output event_kind, output event_time, input ready);
  modport sink   (input valid, input event_kind, input event_time, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/led_classify.sv -----
`default_nettype none

module led_classify #(
  parameter int unsigned POWER_BITS = 24,
  parameter int unsigned TIME_BITS  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  logic [POWER_BITS-1:0]         power_i,
  input  logic [POWER_BITS-1:0]         prev_i,
  input  logic [TIME_BITS-1:0]          time_i,
  input  logic [led_pkg::THR_BITS-1:0]  thr_i,
  output logic                          vld_o,
  output led_pkg::led_class_t           cls_o,
  output logic [TIME_BITS-1:0]          time_o
);
  import led_pkg::*;

  localparam int unsigned CmpBits   = POWER_BITS + SCALE_BITS + 1;
  localparam int unsigned BoundBits = POWER_BITS + THR_BITS;

  logic signed [POWER_BITS:0]  diff;
  logic signed [CmpBits-1:0]   diff_x;
  logic signed [CmpBits-1:0]   scaled_d, scaled_q;
  logic [BoundBits-1:0]        bound_d, bound_q;
  logic [TIME_BITS-1:0]        time_q;
  logic                        vld_q;
  logic signed [CmpBits-1:0]   bound_s;
  logic signed [CmpBits-1:0]   bound_n;

  assign diff   = $signed({1'b0, power_i}) - $signed({1'b0, prev_i});
  assign diff_x = CmpBits'(diff);
  // 1000 * d as 1024*d - 16*d - 8*d
  assign scaled_d = (diff_x <<< 10) - (diff_x <<< 4) - (diff_x <<< 3);
  assign bound_d  = BoundBits'(thr_i) * BoundBits'(power_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && vld_i) begin
      scaled_q <= scaled_d;
      bound_q  <= bound_d;
      time_q   <= time_i;
    end
  end

  assign bound_s = $signed({{(CmpBits-BoundBits){1'b0}}, bound_q});
  assign bound_n = -bound_s;

  always_comb begin
    cls_o.rise   = scaled_q > bound_s;
    cls_o.fall   = scaled_q < bound_n;
    cls_o.steady = !cls_o.rise && (scaled_q > bound_n);
  end

  assign vld_o  = vld_q;
  assign time_o = time_q;

endmodule

`default_nettype wire

// ----- hw/rtl/load_event_detector_core.sv -----
// Load event detector: classifies each power change and emits on/off events.
// Throughput: one input word per cycle; the three-register pipeline stalls only
// while the output register holds a word that is not taken.
// Reset (async, active low) clears phase, previous power and settle start,
// and loads threshold 300 and delay 5000.
`default_nettype none
`include "load_event_detector_core_macros.svh"

module load_event_detector_core #(
  parameter int unsigned POWER_BITS = 24,
  parameter int unsigned TIME_BITS  = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [led_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [led_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  led_in_if.sink                            in_i,
  led_out_if.source                         out_o
);
  import led_pkg::*;

  localparam int unsigned DiffBits = (TIME_BITS > DELAY_BITS) ? TIME_BITS : DELAY_BITS;

  // Configuration registers
  logic [THR_BITS-1:0]   thr_q;
  logic [DELAY_BITS-1:0] delay_q;

  // Pipeline control
  logic adv;
  logic in_acc;
  logic step;

  // Input register stage
  logic                  s1_vld_q;
  logic [POWER_BITS-1:0] s1_pwr_q;
  logic [POWER_BITS-1:0] s1_prev_q;
  logic [TIME_BITS-1:0]  s1_time_q;
  logic [POWER_BITS-1:0] prev_q;

  // Product stage outputs
  logic                  s2_vld;
  led_class_t            s2_cls;
  logic [TIME_BITS-1:0]  s2_time;

  // Event machine
  logic [PHASE_BITS-1:0] phase_d, phase_q;
  logic [TIME_BITS-1:0]  settle_d, settle_q;
  logic [TIME_BITS-1:0]  settle_time;
  logic                  late;
  logic                  emit;
  logic [KIND_BITS-1:0]  kind_d;

  // Output register
  logic                  out_vld_q;
  logic [KIND_BITS-1:0]  kind_q;
  logic [TIME_BITS-1:0]  time_q;

  // Configuration writes; an unknown index is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= THR_RESET;
      delay_q <= DELAY_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_THRESHOLD: thr_q   <= cfg_data_i[THR_BITS-1:0];
        CFG_DELAY:     delay_q <= cfg_data_i[DELAY_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Every stage advances together whenever the output register can take a word.
  assign adv        = !out_vld_q || out_o.ready;
  assign in_i.ready = adv;
  assign in_acc     = in_i.valid && adv;

  // Stage 1: capture the sample together with the power it follows.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      prev_q   <= '0;
    end else begin
      if (adv) begin
        s1_vld_q <= in_i.valid;
      end
      if (in_acc) begin
        prev_q <= in_i.power;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pwr_q  <= in_i.power;
      s1_prev_q <= prev_q;
      s1_time_q <= in_i.sample_time;
    end
  end

  // Stage 2: scaled change and threshold bound, compared on the way out.
  led_classify #(
    .POWER_BITS (POWER_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_classify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .vld_i   (s1_vld_q),
    .power_i (s1_pwr_q),
    .prev_i  (s1_prev_q),
    .time_i  (s1_time_q),
    .thr_i   (thr_q),
    .vld_o   (s2_vld),
    .cls_o   (s2_cls),
    .time_o  (s2_time)
  );

  assign step = adv && s2_vld;

  // Settle time is taken modulo the time width, then compared zero-extended.
  assign settle_time = s2_time - settle_q;
  assign late        = DiffBits'(settle_time) > DiffBits'(delay_q);

  // Stage 3: step the event machine. Rise wins over fall, fall over steady;
  // a change sitting exactly on the negative bound leaves the phase alone.
  always_comb begin
    phase_d  = phase_q;
    settle_d = settle_q;
    emit     = 1'b0;
    kind_d   = KIND_ON_BASIC;
    priority if (s2_cls.rise) begin
      if (phase_q == PH_IDLE || phase_q == PH_ON_WAIT || phase_q == PH_SETTLE) begin
        phase_d = PH_RISE;
      end
    end else if (s2_cls.fall) begin
      unique case (phase_q)
        PH_IDLE:     phase_d = PH_FALL;
        PH_RISE:     phase_d = PH_DROP;
        PH_FALL:     phase_d = PH_DROP;
        PH_OFF_WAIT: phase_d = PH_FALL;
        PH_DROP: begin
          settle_d = s2_time;
          phase_d  = PH_SETTLE;
        end
        PH_SETTLE: begin
          if (late) begin
            emit    = 1'b1;
            kind_d  = KIND_ON_DELAYED;
            phase_d = PH_DELAYED;
          end
        end
        default: ;
      endcase
    end else if (s2_cls.steady) begin
      unique case (phase_q)
        PH_RISE:    phase_d = PH_ON_WAIT;
        PH_ON_WAIT: begin
          emit    = 1'b1;
          kind_d  = KIND_ON_BASIC;
          phase_d = PH_IDLE;
        end
        PH_FALL:    phase_d = PH_OFF_WAIT;
        PH_OFF_WAIT: begin
          emit    = 1'b1;
          kind_d  = KIND_OFF;
          phase_d = PH_IDLE;
        end
        PH_DROP: begin
          emit    = 1'b1;
          kind_d  = KIND_ON_AFTER_FALL;
          phase_d = PH_IDLE;
        end
        PH_SETTLE: begin
          emit    = 1'b1;
          kind_d  = KIND_ON_AFTER_SETTLE;
          phase_d = PH_IDLE;
        end
        PH_DELAYED: phase_d = PH_IDLE;
        default: ;
      endcase
    end else begin
      // No class: hold the phase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      settle_q <= '0;
    end else if (step) begin
      phase_q  <= phase_d;
      settle_q <= settle_d;
    end
  end

  // Output register: load a word only when the step emits one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= s2_vld && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      kind_q <= kind_d;
      time_q <= s2_time;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.event_kind = kind_q;
  assign out_o.event_time = time_q;

  `LED_ASSERT_IMP(a_stall_only_on_backpressure, clk_i, rst_ni,
                  !in_i.ready, out_vld_q && !out_o.ready)
  `LED_ASSERT_NEXT(a_accept_fills_stage, clk_i, rst_ni, in_acc, s1_vld_q)
  `LED_ASSERT_NEXT(a_delayed_enters_wait, clk_i, rst_ni,
                   step && emit && (kind_d == KIND_ON_DELAYED), phase_q == PH_DELAYED)
  `LED_ASSERT_IMP(a_kind_in_range, clk_i, rst_ni, out_vld_q, kind_q <= KIND_ON_DELAYED)

endmodule

`default_nettype wire
